// ===== rtl/core/rss_pkg.sv =====
// Shared types, constants and weight function for the radial stencil spread sum.
// No dependencies; every other file of the block except rss_ram and rss_checker refers to this package by scoped name.
package rss_pkg;

  localparam int CELL_W     = 12;
  localparam int IDX_W      = 12;
  localparam int SUM_W      = 24;
  localparam int WEIGHT_W   = 17;
  localparam int FRAC_DROP  = 8;
  localparam int ROUND_HALF = 128;

  localparam logic [SUM_W-1:0]    SUM_MAX       = 24'hFF_FFFF;
  localparam logic [WEIGHT_W-1:0] CENTRE_WEIGHT = 17'h1_0000;

  // Tag that travels with each window through the pipeline
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
    logic             eof;
  } tag_t;

  // Q.16 weight of a tap at row offset dj, column offset dk:
  // round(32768 / sqrt(dj^2 + dk^2)), centre tap is 1.0
  function automatic logic [WEIGHT_W-1:0] tap_weight(input int dj, input int dk);
    longint unsigned s;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned t;
    s  = 64'(dj * dj + dk * dk);
    lo = 0;
    hi = 32768;
    if (s == 0) begin
      return CENTRE_WEIGHT;
    end
    for (int n = 0; n < 17; n++) begin
      if (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        t   = 2 * mid - 1;
        if (t * t * s <= 64'h1_0000_0000) begin
          lo = mid;
        end else begin
          hi = mid - 1;
        end
      end
    end
    return WEIGHT_W'(lo);
  endfunction

endpackage

// ===== rtl/core/rss_if.sv =====
// Valid/ready channel interfaces for the request and result streams.
// Depends on rss_pkg for payload widths.
interface rss_in_if;
  logic                        valid;
  logic                        ready;
  logic [rss_pkg::CELL_W-1:0]  cell_count;

  modport source (output valid, output cell_count, input ready);
  modport sink   (input valid, input cell_count, output ready);
endinterface

interface rss_out_if;
  logic                        valid;
  logic                        ready;
  logic [rss_pkg::IDX_W-1:0]   cell_index;
  logic [rss_pkg::SUM_W-1:0]   weighted_sum;
  logic                        end_of_frame;

  modport source (output valid, output cell_index, output weighted_sum,
                  output end_of_frame, input ready);
  modport sink   (input valid, input cell_index, input weighted_sum,
                  input end_of_frame, output ready);
endinterface

// ===== rtl/core/rss_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module rss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write when enabled; read every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/rss_window.sv =====
// Stream position counters, line-buffer RAM and the square sample window.
// Depends on rss_pkg and rss_ram.
module rss_window #(
  parameter int GRID_SIZE  = 64,
  parameter int RADIUS     = 4,
  parameter int COUNT_BITS = 12,
  localparam int T         = 2 * RADIUS + 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        accept,
  input  logic [rss_pkg::CELL_W-1:0]  in_count,
  output logic [COUNT_BITS-1:0]       win [0:T-1][0:T-1],
  output logic [T-1:0]                row_ok,
  output logic [T-1:0]                col_ok,
  output rss_pkg::tag_t               tag_o
);

  localparam int LINES       = 2 * RADIUS;
  localparam int FRAME_CELLS = GRID_SIZE * GRID_SIZE;
  localparam int LAG         = RADIUS * GRID_SIZE + RADIUS;
  localparam int FRAME_LEN   = FRAME_CELLS + LAG;
  localparam int PW          = $clog2(FRAME_LEN);
  localparam int QW          = $clog2(FRAME_CELLS);
  localparam int RW          = $clog2(GRID_SIZE);
  localparam int AW          = $clog2(GRID_SIZE);
  localparam int WW          = LINES * COUNT_BITS;

  logic [PW-1:0]         pos_r, pos_nxt;
  logic [RW-1:0]         row_r, row_nxt, col_r, col_nxt;
  logic [QW-1:0]         q_r, q_nxt;
  logic [AW-1:0]         ptr_r, ptr_nxt;
  logic                  produce, in_frame;
  logic [COUNT_BITS-1:0] sample;
  logic [COUNT_BITS-1:0] column [0:T-1];
  logic [WW-1:0]         wr_word, rd_word;
  logic [COUNT_BITS-1:0] win_r [0:T-1][0:T-1];
  logic [T-1:0]          row_ok_nxt, col_ok_nxt, row_ok_r, col_ok_r;
  rss_pkg::tag_t         tag_r, tag_nxt;

  assign in_frame = pos_r < PW'(FRAME_CELLS);
  assign produce  = pos_r >= PW'(LAG);
  assign sample   = in_frame ? COUNT_BITS'(in_count) : '0;

  // Line buffer: one word per column holds the samples of the previous 2R rows
  rss_ram #(.WIDTH(WW), .DEPTH(GRID_SIZE)) u_line_ram (
    .clk   (clk),
    .we    (accept),
    .waddr (ptr_r),
    .wdata (wr_word),
    .raddr (ptr_nxt),
    .rdata (rd_word)
  );

  // Build the new column and the word that pushes it one row down
  always_comb begin
    column[0] = sample;
    for (int i = 1; i < T; i++) begin
      column[i] = rd_word[(i-1)*COUNT_BITS +: COUNT_BITS];
    end
    for (int i = 0; i < LINES; i++) begin
      wr_word[i*COUNT_BITS +: COUNT_BITS] = column[i];
    end
  end

  // Advance position and line pointer on each request, and output cell coordinates once the window lag has passed
  always_comb begin
    pos_nxt = pos_r;
    row_nxt = row_r;
    col_nxt = col_r;
    q_nxt   = q_r;
    ptr_nxt = ptr_r;
    if (accept) begin
      pos_nxt = (pos_r == PW'(FRAME_LEN - 1)) ? '0 : pos_r + 1'b1;
      ptr_nxt = (ptr_r == AW'(GRID_SIZE - 1)) ? '0 : ptr_r + 1'b1;
      if (produce) begin
        q_nxt = (q_r == QW'(FRAME_CELLS - 1)) ? '0 : q_r + 1'b1;
        if (col_r == RW'(GRID_SIZE - 1)) begin
          col_nxt = '0;
          row_nxt = (row_r == RW'(GRID_SIZE - 1)) ? '0 : row_r + 1'b1;
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end
    end
  end

  // Mark window rows and columns that fall inside the grid
  always_comb begin
    int rr;
    int cc;
    for (int i = 0; i < T; i++) begin
      rr = int'(row_r) + RADIUS - i;
      cc = int'(col_r) + RADIUS - i;
      row_ok_nxt[i] = (rr >= 0) && (rr < GRID_SIZE);
      col_ok_nxt[i] = (cc >= 0) && (cc < GRID_SIZE);
    end
  end

  assign tag_nxt = '{valid: accept && produce,
                     idx:   rss_pkg::IDX_W'(q_r),
                     eof:   q_r == QW'(FRAME_CELLS - 1)};

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      row_r <= '0;
      col_r <= '0;
      q_r   <= '0;
      ptr_r <= '0;
      tag_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      row_r <= row_nxt;
      col_r <= col_nxt;
      q_r   <= q_nxt;
      ptr_r <= ptr_nxt;
      if (en) begin
        tag_r <= tag_nxt;
      end
    end
  end

  // Hold masks with the stage
  always_ff @(posedge clk) begin
    if (en) begin
      row_ok_r <= row_ok_nxt;
      col_ok_r <= col_ok_nxt;
    end
  end

  // Shift the window one column on each request
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < T; i++) begin
        win_r[i][0] <= column[i];
        for (int m = 1; m < T; m++) begin
          win_r[i][m] <= win_r[i][m-1];
        end
      end
    end
  end

  assign win    = win_r;
  assign row_ok = row_ok_r;
  assign col_ok = col_ok_r;
  assign tag_o  = tag_r;

endmodule

// ===== rtl/core/rss_mac.sv =====
// Weighted window sum: tap products, row sums, total, then rounding and saturation.
// Depends on rss_pkg.
module rss_mac #(
  parameter int RADIUS     = 4,
  parameter int COUNT_BITS = 12,
  localparam int T         = 2 * RADIUS + 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic [COUNT_BITS-1:0]      win [0:T-1][0:T-1],
  input  logic [T-1:0]               row_ok,
  input  logic [T-1:0]               col_ok,
  input  rss_pkg::tag_t              tag_i,
  output rss_pkg::tag_t              tag_o,
  output logic [rss_pkg::SUM_W-1:0]  sum_o
);

  localparam int PRW = COUNT_BITS + rss_pkg::WEIGHT_W;
  localparam int RSW = PRW + $clog2(T + 1);
  localparam int ACW = RSW + $clog2(T + 1);

  logic [PRW-1:0] prod_r [0:T-1][0:T-1];
  logic [RSW-1:0] row_sum_nxt [0:T-1];
  logic [RSW-1:0] row_sum_r [0:T-1];
  logic [ACW-1:0] total_nxt, total_r;
  logic [63:0]    rnd, shifted;
  rss_pkg::tag_t  t1_r, t2_r, t3_r;

  // Stage 1: one constant multiply per tap, outside taps forced to zero
  for (genvar gi = 0; gi < T; gi++) begin : g_row
    for (genvar gm = 0; gm < T; gm++) begin : g_col
      localparam logic [rss_pkg::WEIGHT_W-1:0] W = rss_pkg::tap_weight(RADIUS - gi, RADIUS - gm);
      always_ff @(posedge clk) begin
        if (en) begin
          prod_r[gi][gm] <= (row_ok[gi] && col_ok[gm]) ?
                            PRW'(win[gi][gm]) * PRW'(W) : '0;
        end
      end
    end
  end

  // Stage 2: sum each window row
  always_comb begin
    for (int i = 0; i < T; i++) begin
      row_sum_nxt[i] = '0;
      for (int m = 0; m < T; m++) begin
        row_sum_nxt[i] = row_sum_nxt[i] + RSW'(prod_r[i][m]);
      end
    end
  end

  // Stage 3: sum the rows
  always_comb begin
    total_nxt = '0;
    for (int i = 0; i < T; i++) begin
      total_nxt = total_nxt + ACW'(row_sum_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      row_sum_r <= row_sum_nxt;
      total_r   <= total_nxt;
    end
  end

  // Advance tags with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_r <= '0;
      t2_r <= '0;
      t3_r <= '0;
    end else if (en) begin
      t1_r <= tag_i;
      t2_r <= t1_r;
      t3_r <= t2_r;
    end
  end

  // Round to 8 fraction bits, halves up, and clamp
  assign rnd     = 64'(total_r) + 64'(rss_pkg::ROUND_HALF);
  assign shifted = rnd >> rss_pkg::FRAC_DROP;
  assign sum_o   = (shifted > 64'(rss_pkg::SUM_MAX)) ? rss_pkg::SUM_MAX
                                                     : shifted[rss_pkg::SUM_W-1:0];
  assign tag_o   = t3_r;

endmodule

// ===== rtl/core/radial_stencil_spread_sum.sv =====
// Radial stencil spread sum: takes one cell count per cycle in raster order while
// the output is not stalled, with RADIUS*GRID_SIZE+RADIUS padding requests after
// each frame, and returns for each cell the window sum with weight 1 at the centre
// and 0.5/distance elsewhere, cells off the grid counting as zero. It sustains one
// request per clock unless stalled; a result's window is completed by the request
// RADIUS*GRID_SIZE+RADIUS positions after its own cell. The line buffer is a single
// GRID_SIZE-deep RAM read one column ahead; its contents need no clearing after
// reset. Depends on rss_pkg, rss_if, rss_window and rss_mac.
module radial_stencil_spread_sum #(
  parameter int GRID_SIZE  = 64,
  parameter int RADIUS     = 4,
  parameter int COUNT_BITS = 12
) (
  input  logic       clk,
  input  logic       rst_n,
  rss_in_if.sink     in_ch,
  rss_out_if.source  out_ch
);

  localparam int T = 2 * RADIUS + 1;

  logic                          en, accept;
  logic [COUNT_BITS-1:0]         win [0:T-1][0:T-1];
  logic [T-1:0]                  row_ok, col_ok;
  rss_pkg::tag_t                 win_tag, mac_tag;
  logic [rss_pkg::SUM_W-1:0]     mac_sum;
  logic                          out_valid_r;
  logic [rss_pkg::IDX_W-1:0]     out_idx_r;
  logic [rss_pkg::SUM_W-1:0]     out_sum_r;
  logic                          out_eof_r;

  // Whole pipeline moves unless the output register is full and stalled
  assign en          = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && en;
  assign in_ch.ready = en;

  rss_window #(
    .GRID_SIZE  (GRID_SIZE),
    .RADIUS     (RADIUS),
    .COUNT_BITS (COUNT_BITS)
  ) u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .accept   (accept),
    .in_count (in_ch.cell_count),
    .win      (win),
    .row_ok   (row_ok),
    .col_ok   (col_ok),
    .tag_o    (win_tag)
  );

  rss_mac #(
    .RADIUS     (RADIUS),
    .COUNT_BITS (COUNT_BITS)
  ) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .win    (win),
    .row_ok (row_ok),
    .col_ok (col_ok),
    .tag_i  (win_tag),
    .tag_o  (mac_tag),
    .sum_o  (mac_sum)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= mac_tag.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_idx_r <= mac_tag.idx;
      out_sum_r <= mac_sum;
      out_eof_r <= mac_tag.eof;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.cell_index   = out_idx_r;
  assign out_ch.weighted_sum = out_sum_r;
  assign out_ch.end_of_frame = out_eof_r;

endmodule

// ===== rtl/core/rss_checker.sv =====
// Port-level checker for the radial stencil spread sum, bound to the top level.
// Depends on the top level's ports only.
module rss_checker #(
  parameter int GRID_SIZE = 64
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [11:0] out_cell_index,
  input logic [23:0] out_weighted_sum,
  input logic        out_end_of_frame
);

  localparam logic [11:0] LAST_IDX = 12'(GRID_SIZE * GRID_SIZE - 1);

  logic        seen_r;
  logic [11:0] exp_r;

  // Track the index the next result should carry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
      exp_r  <= '0;
    end else if (out_valid && out_ready) begin
      seen_r <= 1'b1;
      exp_r  <= out_end_of_frame ? 12'd0 : out_cell_index + 12'd1;
    end
  end

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cell_index) &&
    $stable(out_weighted_sum) && $stable(out_end_of_frame))
    else $error("stalled result changed");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("request refused with empty output");

  a_eof_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_frame |-> out_cell_index == LAST_IDX)
    else $error("end of frame on wrong cell");

  a_index_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && seen_r |-> out_cell_index == exp_r)
    else $error("result index out of order");

endmodule

bind radial_stencil_spread_sum rss_checker #(.GRID_SIZE(GRID_SIZE)) u_rss_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_cell_index   (out_ch.cell_index),
  .out_weighted_sum (out_ch.weighted_sum),
  .out_end_of_frame (out_ch.end_of_frame)
);

// ===== tb/sv/tb_rss_scoreboard.sv =====
// Expected-sum scoreboard for the radial stencil spread sum testbench.
// Depends on rss_pkg for field widths; holds its own window history and frame position.
`timescale 1ns / 1ps

class rss_sum_board;
  localparam int GRID    = 64;
  localparam int RAD     = 4;
  localparam int CBITS   = 12;
  localparam int CELLS   = GRID * GRID;
  localparam int LAG     = RAD * GRID + RAD;
  localparam int DEPTH   = 2 * LAG + 1;
  localparam int FRM_LEN = CELLS + LAG;

  typedef struct {
    logic [rss_pkg::IDX_W-1:0] idx;
    logic [rss_pkg::SUM_W-1:0] sum;
    logic                      eof;
  } sum_rec_t;

  logic [CBITS-1:0] history [DEPTH];
  int unsigned      head;
  int unsigned      frame_pos;
  longint unsigned  kernel [-RAD:RAD][-RAD:RAD];
  sum_rec_t         pending_sums [$];
  int               mismatches;
  int               sums_checked;

  function new();
    longint unsigned s, lo, hi, mid, t;
    for (int j = -RAD; j <= RAD; j++) begin
      for (int k = -RAD; k <= RAD; k++) begin
        s = j * j + k * k;
        if (s == 0) begin
          kernel[j][k] = 65536;
        end else begin
          // round(32768/sqrt(s)) by bisection on the squared half-step
          lo = 0;
          hi = 32768;
          while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            t   = 2 * mid - 1;
            if (t * t * s <= 64'h1_0000_0000) lo = mid;
            else hi = mid - 1;
          end
          kernel[j][k] = lo;
        end
      end
    end
    foreach (history[i]) history[i] = '0;
    head = 0;
    frame_pos = 0;
    mismatches = 0;
    sums_checked = 0;
  endfunction

  // Record one accepted request and queue the sum it completes
  function void note_cell(logic [rss_pkg::CELL_W-1:0] cnt);
    int unsigned     newest, q, age, slot;
    int              r, c;
    longint unsigned acc, total;
    sum_rec_t        rec;
    newest = head;
    history[newest] = (frame_pos < CELLS) ? cnt[CBITS-1:0] : '0;
    head = (newest + 1) % DEPTH;
    if (frame_pos >= LAG) begin
      q = frame_pos - LAG;
      r = q / GRID;
      c = q % GRID;
      acc = 0;
      for (int j = -RAD; j <= RAD; j++) begin
        for (int k = -RAD; k <= RAD; k++) begin
          if (r + j >= 0 && r + j < GRID && c + k >= 0 && c + k < GRID) begin
            age  = LAG - (j * GRID + k);
            slot = (newest + DEPTH - age) % DEPTH;
            acc += history[slot] * kernel[j][k];
          end
        end
      end
      total = (acc + 128) >> 8;
      if (total > 64'hFF_FFFF) total = 64'hFF_FFFF;
      rec.idx = q[11:0];
      rec.sum = total[23:0];
      rec.eof = (q == CELLS - 1);
      pending_sums.push_back(rec);
    end
    frame_pos = (frame_pos + 1 >= FRM_LEN) ? 0 : frame_pos + 1;
  endfunction

  // Compare one accepted result with the oldest queued sum
  function void check_sum(logic [rss_pkg::IDX_W-1:0] idx, logic [rss_pkg::SUM_W-1:0] sum,
                          logic eof);
    sum_rec_t rec;
    sums_checked++;
    if (pending_sums.size() == 0) begin
      report_err($sformatf("unexpected result idx=%0d sum=%0h", idx, sum));
      return;
    end
    rec = pending_sums.pop_front();
    if (idx !== rec.idx)
      report_err($sformatf("cell_index got %0d want %0d", idx, rec.idx));
    if (sum !== rec.sum)
      report_err($sformatf("weighted_sum idx %0d got %0h want %0h", rec.idx, sum, rec.sum));
    if (eof !== rec.eof)
      report_err($sformatf("end_of_frame idx %0d got %0b want %0b", rec.idx, eof, rec.eof));
  endfunction

  function void report_err(string msg);
    mismatches++;
    if (mismatches <= 40) $display("mismatch: %s", msg);
  endfunction
endclass

// ===== tb/sv/tb_radial_stencil_spread_sum.sv =====
// Top-level testbench for radial_stencil_spread_sum: random-paced raster cells in segments.
// Depends on rss_pkg, rss_if, the block's RTL and tb_rss_scoreboard.sv.
`timescale 1ns / 1ps

module tb_radial_stencil_spread_sum;
  localparam int SEG_CELLS = 320;
  localparam int WD_LIMIT  = 5000;

  typedef enum int {PAT_MAX, PAT_ZERO, PAT_CHECKER, PAT_SPARSE, PAT_RANDOM} pat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rss_in_if  in_ch ();
  rss_out_if out_ch ();

  radial_stencil_spread_sum i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  rss_sum_board board = new();
  int  idle_cycles = 0;
  int  cells_sent = 0;
  int  segs_sent = 0;
  int  out_wait = 0;

  always #5 clk = ~clk;

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.cell_count = '0;
    out_ch.ready     = 1'b0;
  end

  // Sample both handshakes and feed the scoreboard
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) board.note_cell(in_ch.cell_count);
      if (out_ch.valid && out_ch.ready)
        board.check_sum(out_ch.cell_index, out_ch.weighted_sum, out_ch.end_of_frame);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // Stop the run if nothing moves for too long
  always @(posedge clk) begin
    if (idle_cycles >= WD_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", WD_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Randomly hold ready low after each taken result, else keep it high
  always @(posedge clk) begin
    int w;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_wait     <= 0;
    end else if (out_ch.valid && out_ch.ready) begin
      w = $urandom_range(0, 9);
      out_wait     <= w;
      out_ch.ready <= (w == 0);
    end else if (out_wait > 0) begin
      out_wait     <= out_wait - 1;
      out_ch.ready <= (out_wait == 1);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Send one request, holding valid until it is taken
  task automatic send_cell(logic [11:0] cnt, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.cell_count <= cnt;
    do @(posedge clk); while (!in_ch.ready);
    cells_sent++;
  endtask

  function automatic logic [11:0] pick_count(pat_t pat, int i);
    case (pat)
      PAT_MAX:     return 12'hFFF;
      PAT_ZERO:    return '0;
      PAT_CHECKER: return (i % 2) ? 12'hAAA : 12'h555;
      PAT_SPARSE:  return ($urandom_range(0, 7) == 0) ? 12'($urandom) : '0;
      default:     return 12'($urandom);
    endcase
  endfunction

  // One stretch of raster cells with a single pattern
  task automatic send_segment(pat_t pat, bit burst);
    for (int i = 0; i < SEG_CELLS; i++) send_cell(pick_count(pat, i), burst || i[3]);
    segs_sent++;
  endtask

  // Drop valid and hold off until every pending sum is back
  task automatic pause_and_drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.pending_sums.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // All-max burst, then all-zero, then a full pause
    send_segment(PAT_MAX, 1'b1);
    send_segment(PAT_ZERO, 1'b0);
    pause_and_drain();
    send_segment(PAT_CHECKER, 1'b0);
    send_segment(PAT_SPARSE, 1'b0);
    send_segment(PAT_RANDOM, 1'b0);
    pause_and_drain();
    repeat (50) @(posedge clk);
    $display("covered %0d requests in %0d pattern runs, %0d sums checked",
             cells_sent, segs_sent, board.sums_checked);
    $display("patterns: all-max, zero, checkerboard, sparse and dense random");
    if (board.mismatches == 0 && board.pending_sums.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/core/rss_pkg.sv
rtl/core/rss_if.sv
rtl/core/rss_ram.sv
rtl/core/rss_window.sv
rtl/core/rss_mac.sv
rtl/core/radial_stencil_spread_sum.sv
rtl/core/rss_checker.sv
tb/sv/tb_rss_scoreboard.sv
tb/sv/tb_radial_stencil_spread_sum.sv
